// ===== rtl/wcls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcls_pkg: shared types and constants for the leaf statistics block
// Command codes, configuration indexes, the controller state type and the
// control group that drives the row of class cells.
// ----------------------------------------------------------------------------
package wcls_pkg;

    // Default number of class cells in the ring.
    localparam int NUM_CLASSES_DEF = 8;

    // Command codes.
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_QUERY  = 3'd3;
    localparam logic [2:0] CMD_LOAD   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOSS_MODE    = 2'd0;
    localparam logic [1:0] CFG_LOSS_SCALE   = 2'd1;
    localparam logic [1:0] CFG_MISSING_LEAF = 2'd2;
    localparam logic [1:0] CFG_NUM_CLASSES  = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Result and divider widths.
    localparam int ERR_W   = 48;
    localparam int DIV_Q_W = 48;
    localparam int DIV_C_W = 6;
    localparam int BIT_W   = 6;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [23:0] MAX24 = 24'hFF_FFFF;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_WIN,
        ST_LOSS,
        ST_CONF,
        ST_CDIV,
        ST_MISC,
        ST_MUL,
        ST_LCHK,
        ST_LDIV,
        ST_CAP,
        ST_OUT
    } t_state;

    // Control shared by every cell of the ring.
    typedef struct packed {
        logic shift;
        logic clr_sums;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/wcls_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcls_req_if: command channel
// Valid/ready channel that carries one command transaction.
// ----------------------------------------------------------------------------
interface wcls_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [2:0]         class_index;
    logic signed [15:0] target_value;
    logic [15:0]        sample_weight;

    modport source (output valid, cmd, class_index, target_value, sample_weight,
                    input ready);
    modport sink   (input valid, cmd, class_index, target_value, sample_weight,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/wcls_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcls_rsp_if: result channel
// Valid/ready channel that carries one result transaction.
// ----------------------------------------------------------------------------
interface wcls_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] predicted_value;
    logic [15:0]        confidence;
    logic [47:0]        loss_error;
    logic [47:0]        misclass_error;
    logic [47:0]        capped_error;
    logic               empty_leaf;
    logic               bad_target;

    modport source (output valid, predicted_value, confidence, loss_error,
                    misclass_error, capped_error, empty_leaf, bad_target,
                    input ready);
    modport sink   (input valid, predicted_value, confidence, loss_error,
                    misclass_error, capped_error, empty_leaf, bad_target,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/wcls_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcls_cell: one class cell of the ring
// Holds a class value and its weight sum and takes its neighbor's pair on
// every shift.
// ----------------------------------------------------------------------------
module wcls_cell (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire wcls_pkg::t_cell_ctl i_ctl,
    input  wire                    i_ld,
    input  wire  signed [15:0]     i_ld_val,
    input  wire  signed [15:0]     i_nb_val,
    input  wire         [31:0]     i_nb_sum,
    output logic signed [15:0]     o_val,
    output logic        [31:0]     o_sum
);
    import wcls_pkg::*;

    logic signed [15:0] r_val;
    logic        [31:0] r_sum;

    // Class value: written by a load, otherwise moves with the ring.
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_val <= i_ld_val;
        end else if (i_ctl.shift) begin
            r_val <= i_nb_val;
        end
    end

    // Weight sum: cleared by reset or a clear command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr_sums) begin
            r_sum <= '0;
        end else if (i_ctl.shift) begin
            r_sum <= i_nb_sum;
        end
    end

    assign o_val = r_val;
    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== rtl/wcls_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcls_div: restoring divider, one quotient bit per cycle
// Starts from a partial remainder below the divisor and shifts in the
// remaining dividend bits, most significant first.
// ----------------------------------------------------------------------------
module wcls_div (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire  [31:0]                       i_rem,
    input  wire  [wcls_pkg::DIV_Q_W-1:0]      i_low,
    input  wire  [wcls_pkg::DIV_C_W-1:0]      i_count,
    input  wire  [31:0]                       i_divisor,
    output logic                              o_done,
    output logic [wcls_pkg::DIV_Q_W-1:0]      o_quot
);
    import wcls_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_C_W-1:0]   r_cnt;
    logic [31:0]          r_rem;
    logic [DIV_Q_W-1:0]   r_low;
    logic [DIV_Q_W-1:0]   r_quot;
    logic [32:0]          w_trial;
    logic                 w_ge;

    // Trial subtraction of the shifted remainder.
    assign w_trial = {r_rem, r_low[DIV_Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_count;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DIV_C_W'(1));
            r_busy <= (r_cnt != DIV_C_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Data path: remainder, pending dividend bits and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_low  <= i_low;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? 32'(w_trial - {1'b0, i_divisor}) : w_trial[31:0];
            r_low  <= {r_low[DIV_Q_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/weighted_class_leaf_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_class_leaf_stats: decision-tree leaf class statistics
// A ring of class cells rotates past a controller that matches targets,
// finds the heaviest class and accumulates the weighted loss; a serial
// multiplier and a shared divider finish the scaled results.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       contents
//  i_req     in   valid/ready     cmd, class_index, target_value, sample_weight
//  o_rsp     out  valid/ready     predicted_value .. bad_target
//  i_cfg_*   in   write enable    register index, write data
//
//  A transaction makes a winner pass of the ring, after an update pass for add
//  and remove. When the leaf is empty, is the missing-value leaf or has no
//  weight, the result then goes to the output register. A full result adds a
//  loss pass, a confidence divide, the serial multiply with its setup, the
//  loss check with its divide and the cap.
//  Reset is synchronous; it clears the weight sums and counters and sets the configuration registers.
//  A finished result waits in the output register while the next command is
//  taken; a result is only written there once the previous one has left.
// ----------------------------------------------------------------------------
module weighted_class_leaf_stats #(
    parameter int NUM_CLASSES = wcls_pkg::NUM_CLASSES_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    wcls_req_if.sink                            i_req,
    wcls_rsp_if.source                          o_rsp,
    input  wire                                 i_cfg_we,
    input  wire  [wcls_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [wcls_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import wcls_pkg::*;

    localparam int CNT_W = $clog2(NUM_CLASSES + 3);
    localparam int ACC_W = 64 + $clog2(NUM_CLASSES);
    localparam int P_W   = ACC_W + 48;

    // Configuration registers.
    logic        r_loss_mode;
    logic [23:0] r_loss_scale;
    logic        r_missing;
    logic [3:0]  r_num_cls;

    // Controller.
    t_state      r_state, n_state;
    t_cell_ctl   w_ctl;
    logic        w_accept;
    logic        w_last;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] w_n;
    logic        w_in_use;

    // Latched command.
    logic [2:0]         r_cmd;
    logic signed [15:0] r_tgt;
    logic [15:0]        r_w;

    // Leaf counters.
    logic [23:0] r_rc;
    logic [31:0] r_tw;

    // Ring.
    logic signed [15:0] w_val [NUM_CLASSES];
    logic        [31:0] w_sum [NUM_CLASSES];
    logic               w_ld  [NUM_CLASSES];
    logic signed [15:0] w_head_val;
    logic        [31:0] w_head_sum;
    logic        [31:0] w_head_sum_n;

    // Update pass.
    logic        r_found;
    logic        r_bad;
    logic        w_match;
    logic [32:0] w_sat_add;

    // Winner pass.
    logic signed [15:0] r_win_val;
    logic        [31:0] r_win_sum;
    logic               w_take;
    logic signed [15:0] w_win_val_n;

    // Loss pass pipeline.
    logic signed [16:0] w_diff;
    logic [15:0]        r_d;
    logic [31:0]        r_s1, r_s2, r_t;
    logic [63:0]        r_pp;
    logic               r_v1, r_v2, r_v3;
    logic [ACC_W-1:0]   r_acc;

    // Finishing arithmetic.
    logic [16:0]        r_c;
    logic [47:0]        r_mul_m;
    logic [P_W-1:0]     r_mcand;
    logic [P_W-1:0]     r_p;
    logic [BIT_W-1:0]   r_bit;
    logic [55:0]        w_cap_prod;
    logic               w_loss_sat;

    // Divider.
    logic                 w_div_start;
    logic [31:0]          w_div_rem;
    logic [DIV_Q_W-1:0]   w_div_low;
    logic [DIV_C_W-1:0]   w_div_cnt;
    logic                 w_div_done;
    logic [DIV_Q_W-1:0]   w_div_q;

    // Result fields.
    logic signed [15:0] r_pred;
    logic [15:0]        r_conf;
    logic [47:0]        r_loss, r_miss, r_cap, r_capped;
    logic               r_empty;
    logic               w_out_load;

    // Output register.
    logic               r_o_valid;
    logic signed [15:0] r_o_pred;
    logic [15:0]        r_o_conf;
    logic [47:0]        r_o_loss, r_o_miss, r_o_capped;
    logic               r_o_empty, r_o_bad;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_mode  <= 1'b0;
            r_loss_scale <= 24'd65536;
            r_missing    <= 1'b0;
            r_num_cls    <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOSS_MODE:    r_loss_mode  <= i_cfg_data[0];
                CFG_LOSS_SCALE:   r_loss_scale <= i_cfg_data[23:0];
                CFG_MISSING_LEAF: r_missing    <= i_cfg_data[0];
                CFG_NUM_CLASSES:  r_num_cls    <= i_cfg_data[3:0];
                default:          r_missing    <= r_missing;
            endcase
        end
    end

    // Active class count, clamped to one .. NUM_CLASSES.
    always_comb begin
        if (r_num_cls == 4'd0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_num_cls) > 32'(NUM_CLASSES)) begin
            w_n = CNT_W'(NUM_CLASSES);
        end else begin
            w_n = CNT_W'(r_num_cls);
        end
    end

    assign w_in_use = (r_cnt < w_n);
    assign w_last   = (r_cnt == CNT_W'(NUM_CLASSES - 1));
    assign w_accept = i_req.valid && i_req.ready;

    // Ring of cells; the head feeds back into the tail with its updated sum.
    assign w_head_val = w_val[0];
    assign w_head_sum = w_sum[0];

    for (genvar gi = 0; gi < NUM_CLASSES; gi++) begin : g_cell
        logic signed [15:0] w_nb_val;
        logic        [31:0] w_nb_sum;

        if (gi == NUM_CLASSES - 1) begin : g_tail
            assign w_nb_val = w_head_val;
            assign w_nb_sum = w_head_sum_n;
        end else begin : g_mid
            assign w_nb_val = w_val[gi+1];
            assign w_nb_sum = w_sum[gi+1];
        end

        assign w_ld[gi] = w_accept && (i_req.cmd == CMD_LOAD) &&
                          (32'(i_req.class_index) == gi);

        wcls_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_ld     (w_ld[gi]),
            .i_ld_val (i_req.target_value),
            .i_nb_val (w_nb_val),
            .i_nb_sum (w_nb_sum),
            .o_val    (w_val[gi]),
            .o_sum    (w_sum[gi])
        );
    end

    // Target match and saturating update of the head sum.
    assign w_match   = (r_state == ST_UPD) && w_in_use && !r_found &&
                       (w_head_val == r_tgt);
    assign w_sat_add = {1'b0, w_head_sum} + {17'd0, r_w};

    always_comb begin
        w_head_sum_n = w_head_sum;
        if (w_match) begin
            if (r_cmd == CMD_ADD) begin
                w_head_sum_n = w_sat_add[32] ? MAX32 : w_sat_add[31:0];
            end else begin
                w_head_sum_n = (w_head_sum < {16'd0, r_w}) ? 32'd0
                             : w_head_sum - {16'd0, r_w};
            end
        end
    end

    // First heaviest class.
    assign w_take      = (r_cnt == '0) || (w_in_use && (w_head_sum > r_win_sum));
    assign w_win_val_n = w_take ? w_head_val : r_win_val;

    // Loss saturation: the quotient reaches 2^48.
    assign w_loss_sat = (r_p[P_W-1:48] >= ACC_W'(r_tw));
    assign w_cap_prod = 56'(r_tw) * 56'(r_loss_scale);
    assign w_out_load = (r_state == ST_OUT) && (!r_o_valid || o_rsp.ready);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and controls.
    always_comb begin
        n_state      = r_state;
        w_ctl        = '0;
        w_div_start  = 1'b0;
        w_div_rem    = '0;
        w_div_low    = '0;
        w_div_cnt    = '0;
        i_req.ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    if (i_req.cmd == CMD_ADD || i_req.cmd == CMD_REMOVE) begin
                        n_state = ST_UPD;
                    end else begin
                        n_state = ST_WIN;
                    end
                    w_ctl.clr_sums = (i_req.cmd == CMD_CLEAR);
                end
            end
            ST_UPD: begin
                w_ctl.shift = 1'b1;
                if (w_last) n_state = ST_WIN;
            end
            ST_WIN: begin
                w_ctl.shift = 1'b1;
                if (w_last) begin
                    if (r_rc == '0 || r_missing || r_tw == '0) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_LOSS;
                    end
                end
            end
            ST_LOSS: begin
                w_ctl.shift = (r_cnt < CNT_W'(NUM_CLASSES));
                if (r_cnt == CNT_W'(NUM_CLASSES + 2)) n_state = ST_CONF;
            end
            ST_CONF: begin
                if (r_win_sum >= r_tw) begin
                    n_state = ST_MISC;
                end else begin
                    w_div_start = 1'b1;
                    w_div_rem   = r_win_sum;
                    w_div_cnt   = DIV_C_W'(16);
                    n_state     = ST_CDIV;
                end
            end
            ST_CDIV: begin
                if (w_div_done) n_state = ST_MISC;
            end
            ST_MISC: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_bit == BIT_W'(47)) n_state = ST_LCHK;
            end
            ST_LCHK: begin
                if (w_loss_sat) begin
                    n_state = ST_CAP;
                end else begin
                    w_div_start = 1'b1;
                    w_div_rem   = r_p[79:48];
                    w_div_low   = r_p[47:0];
                    w_div_cnt   = DIV_C_W'(48);
                    n_state     = ST_LDIV;
                end
            end
            ST_LDIV: begin
                if (w_div_done) n_state = ST_CAP;
            end
            ST_CAP: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Shared divider for confidence and loss.
    wcls_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_rem     (w_div_rem),
        .i_low     (w_div_low),
        .i_count   (w_div_cnt),
        .i_divisor (r_tw),
        .o_done    (w_div_done),
        .o_quot    (w_div_q)
    );

    // Pass counter and leaf counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rc    <= '0;
            r_tw    <= '0;
            r_found <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    if (w_accept) begin
                        r_bad <= 1'b0;
                        if (i_req.cmd == CMD_CLEAR) begin
                            r_rc <= '0;
                            r_tw <= '0;
                        end
                    end
                end
                ST_UPD: begin
                    r_cnt <= w_last ? '0 : r_cnt + 1'b1;
                    if (w_match) r_found <= 1'b1;
                    if (w_last) begin
                        if (r_found || w_match) begin
                            if (r_cmd == CMD_ADD) begin
                                if (r_rc < MAX24) r_rc <= r_rc + 1'b1;
                                r_tw <= (r_tw > MAX32 - {16'd0, r_w}) ? MAX32
                                      : r_tw + {16'd0, r_w};
                            end else begin
                                if (r_rc != '0) r_rc <= r_rc - 1'b1;
                                r_tw <= (r_tw < {16'd0, r_w}) ? 32'd0
                                      : r_tw - {16'd0, r_w};
                            end
                        end else begin
                            r_bad <= 1'b1;
                        end
                    end
                end
                ST_WIN: begin
                    r_cnt <= w_last ? '0 : r_cnt + 1'b1;
                end
                ST_LOSS: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    // Latched command fields.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.cmd;
            r_tgt <= i_req.target_value;
            r_w   <= i_req.sample_weight;
        end
    end

    // Winner tracking and early result fields.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pred  <= '0;
            r_conf  <= '0;
            r_loss  <= '0;
            r_miss  <= '0;
            r_capped <= '0;
            r_empty <= 1'b0;
        end
        if (r_state == ST_WIN) begin
            r_win_val <= w_win_val_n;
            if (w_take) r_win_sum <= w_head_sum;
            if (w_last) begin
                if (r_rc == '0) begin
                    r_empty <= 1'b1;
                end else begin
                    r_pred <= w_win_val_n;
                    if (r_missing) begin
                        r_miss <= {8'd0, r_tw, 8'd0};
                    end else if (r_tw == '0) begin
                        r_miss <= {8'd0, r_rc, 16'd0};
                    end
                end
            end
        end
        if (r_state == ST_MISC) begin
            r_conf <= r_c[16] ? 16'hFFFF : r_c[15:0];
            r_miss <= 48'(17'd65536 - r_c) * 48'(r_rc);
            r_cap  <= w_cap_prod[55:8];
        end
        if (r_state == ST_LCHK && w_loss_sat) r_loss <= MAX48;
        if (r_state == ST_LDIV && w_div_done) r_loss <= w_div_q;
        if (r_state == ST_CAP) r_capped <= (r_loss > r_cap) ? r_cap : r_loss;
    end

    // Loss pass: distance, square in squared-loss mode, weight product, accumulate.
    assign w_diff = {r_win_val[15], r_win_val} - {w_head_val[15], w_head_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_LOSS) && w_ctl.shift && w_in_use;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d  <= w_diff[16] ? 16'(-w_diff) : w_diff[15:0];
        r_s1 <= w_head_sum;
        r_t  <= r_loss_mode ? 32'(r_d) * 32'(r_d) : {16'd0, r_d};
        r_s2 <= r_s1;
        r_pp <= 64'(r_t) * 64'(r_s2);
        if (r_state == ST_WIN) begin
            r_acc <= '0;
        end else if (r_state == ST_LOSS && r_v3) begin
            r_acc <= r_acc + ACC_W'(r_pp);
        end
    end

    // Confidence quotient and serial multiply by loss_scale * row_count.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CONF && r_win_sum >= r_tw) r_c <= 17'd65536;
        if (r_state == ST_CDIV && w_div_done) r_c <= {1'b0, w_div_q[15:0]};
        if (r_state == ST_MISC) begin
            r_mul_m <= 48'(r_rc) * 48'(r_loss_scale);
            r_mcand <= P_W'(r_acc);
            r_p     <= '0;
            r_bit   <= '0;
        end
        if (r_state == ST_MUL) begin
            if (r_mul_m[0]) r_p <= r_p + r_mcand;
            r_mcand <= {r_mcand[P_W-2:0], 1'b0};
            r_mul_m <= {1'b0, r_mul_m[47:1]};
            r_bit   <= r_bit + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_pred   <= r_pred;
            r_o_conf   <= r_conf;
            r_o_loss   <= r_loss;
            r_o_miss   <= r_miss;
            r_o_capped <= r_capped;
            r_o_empty  <= r_empty;
            r_o_bad    <= r_bad;
        end
    end

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.predicted_value = r_o_pred;
    assign o_rsp.confidence      = r_o_conf;
    assign o_rsp.loss_error      = r_o_loss;
    assign o_rsp.misclass_error  = r_o_miss;
    assign o_rsp.capped_error    = r_o_capped;
    assign o_rsp.empty_leaf      = r_o_empty;
    assign o_rsp.bad_target      = r_o_bad;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the weighted class leaf statistics block
// Drives command transactions over the request channel and checks every
// result against an in-bench predictor of the leaf state, under several
// register settings, random idle and stall patterns and a long output stall.
// ----------------------------------------------------------------------------
module tb;
    import wcls_pkg::*;

    localparam int NCLS = NUM_CLASSES_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 200;

    // Spare command codes, which the block treats as a query.
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [15:0] pred;
        logic [15:0]        conf;
        logic [47:0]        loss;
        logic [47:0]        miss;
        logic [47:0]        capped;
        logic               empty;
        logic               bad;
    } t_leaf_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wcls_req_if req_ch ();
    wcls_rsp_if rsp_ch ();

    weighted_class_leaf_stats dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted leaf state and register copies.
    logic               mode_sq;
    logic [23:0]        scale_q;
    logic               missing_mode;
    logic [3:0]         class_limit;
    logic signed [15:0] class_tab [NCLS];
    logic [31:0]        class_sum [NCLS];
    logic [23:0]        rows;
    logic [31:0]        weight_total;

    t_leaf_result pending_results[$];
    int  fail_count;
    int  sent_count;
    int  checked_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  cycle_count;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending_results.size());
                $display("weighted_class_leaf_stats regression: fail");
                $finish;
            end
        end
    end

    function automatic int active_classes();
        if (class_limit == 4'd0) begin
            return 1;
        end
        if (int'(class_limit) > NCLS) begin
            return NCLS;
        end
        return int'(class_limit);
    endfunction

    // Apply one command to the predicted state and return its result.
    function automatic t_leaf_result apply_command(logic [2:0] cmd, logic [2:0] idx,
                                                   logic signed [15:0] tgt,
                                                   logic [15:0] w);
        t_leaf_result r;
        int n;
        int k;
        int win;
        int diff;
        logic [63:0]  absd;
        logic [127:0] acc;
        logic [63:0]  frac;
        logic [55:0]  cap;
        n = active_classes();
        k = -1;
        r = '{pred: '0, conf: '0, loss: '0, miss: '0, capped: '0, empty: 1'b0, bad: 1'b0};

        case (cmd)
            CMD_CLEAR: begin
                foreach (class_sum[i]) class_sum[i] = '0;
                rows = '0;
                weight_total = '0;
            end
            CMD_ADD, CMD_REMOVE: begin
                for (int i = n - 1; i >= 0; i--) begin
                    if (class_tab[i] == tgt) k = i;
                end
                if (k < 0) begin
                    r.bad = 1'b1;
                end else if (cmd == CMD_ADD) begin
                    if (rows != MAX24) rows++;
                    weight_total = ({1'b0, weight_total} + w > {1'b0, MAX32}) ?
                                   MAX32 : weight_total + w;
                    class_sum[k] = ({1'b0, class_sum[k]} + w > {1'b0, MAX32}) ?
                                   MAX32 : class_sum[k] + w;
                end else begin
                    if (rows != 0) rows--;
                    weight_total = (weight_total < w) ? '0 : weight_total - w;
                    class_sum[k] = (class_sum[k] < w) ? '0 : class_sum[k] - w;
                end
            end
            CMD_LOAD: begin
                class_tab[idx] = tgt;
            end
            default: ;
        endcase

        if (rows == 0) begin
            r.empty = 1'b1;
            return r;
        end
        win = 0;
        for (int i = 1; i < n; i++) begin
            if (class_sum[i] > class_sum[win]) win = i;
        end
        r.pred = class_tab[win];
        if (missing_mode) begin
            r.miss = {8'd0, weight_total, 8'd0};
        end else if (weight_total == 0) begin
            r.miss = {8'd0, rows, 16'd0};
        end else begin
            frac = ({32'd0, class_sum[win]} << 16) / weight_total;
            if (frac > 64'd65536) frac = 64'd65536;
            r.conf = (frac > 64'd65535) ? 16'hFFFF : frac[15:0];
            r.miss = (48'd65536 - frac[47:0]) * rows;
            acc = '0;
            for (int i = 0; i < n; i++) begin
                diff = int'(class_tab[win]) - int'(class_tab[i]);
                if (diff < 0) diff = -diff;
                absd = mode_sq ? 64'(diff) * 64'(diff) : 64'(diff);
                acc += 128'(absd) * 128'(class_sum[i]);
            end
            acc = acc * scale_q;
            acc = acc * rows;
            acc = acc / weight_total;
            r.loss = (acc > 128'(MAX48)) ? MAX48 : acc[47:0];
            cap = (56'(weight_total) * 56'(scale_q)) >> 8;
            r.capped = (r.loss > cap[47:0]) ? cap[47:0] : r.loss;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 checked_count, field, got, want);
        fail_count++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_leaf_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("result transaction arrived with none outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.predicted_value !== want.pred)
                    report_mismatch("predicted_value", 64'(rsp_ch.predicted_value), 64'(want.pred));
                if (rsp_ch.confidence !== want.conf)
                    report_mismatch("confidence", 64'(rsp_ch.confidence), 64'(want.conf));
                if (rsp_ch.loss_error !== want.loss)
                    report_mismatch("loss_error", 64'(rsp_ch.loss_error), 64'(want.loss));
                if (rsp_ch.misclass_error !== want.miss)
                    report_mismatch("misclass_error", 64'(rsp_ch.misclass_error), 64'(want.miss));
                if (rsp_ch.capped_error !== want.capped)
                    report_mismatch("capped_error", 64'(rsp_ch.capped_error), 64'(want.capped));
                if (rsp_ch.empty_leaf !== want.empty)
                    report_mismatch("empty_leaf", 64'(rsp_ch.empty_leaf), 64'(want.empty));
                if (rsp_ch.bad_target !== want.bad)
                    report_mismatch("bad_target", 64'(rsp_ch.bad_target), 64'(want.bad));
            end
            checked_count++;
        end
    end

    // Receiver ready, with random stalls and an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Send one command transaction and record its predicted result.
    task automatic send_cmd(logic [2:0] cmd, logic [2:0] idx, logic signed [15:0] tgt,
                            logic [15:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.class_index   <= idx;
        req_ch.target_value  <= tgt;
        req_ch.sample_weight <= w;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(apply_command(cmd, idx, tgt, w));
        sent_count++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; the block must be idle.
    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_LOSS_MODE:    mode_sq = data[0];
            CFG_LOSS_SCALE:   scale_q = data;
            CFG_MISSING_LEAF: missing_mode = data[0];
            CFG_NUM_CLASSES:  class_limit = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic mode, logic [23:0] scale, logic miss, logic [3:0] ncls);
        drain();
        write_reg(CFG_LOSS_MODE, {23'd0, mode});
        write_reg(CFG_LOSS_SCALE, scale);
        write_reg(CFG_MISSING_LEAF, {23'd0, miss});
        write_reg(CFG_NUM_CLASSES, {20'd0, ncls});
    endtask

    // Target of a well-formed sample: one of the active class values.
    function automatic logic signed [15:0] known_target();
        return class_tab[$urandom_range(0, active_classes() - 1)];
    endfunction

    // Directed corner cases: table load, empty leaf, weight extremes,
    // unknown targets, floor at zero on remove, spare codes and clear.
    task automatic test_directed();
        send_cmd(CMD_QUERY, 3'd0, 16'sd0, 16'd0);
        send_cmd(CMD_LOAD, 3'd0, -16'sd32768, 16'hFFFF);
        send_cmd(CMD_LOAD, 3'd1, 16'sd32767, 16'd0);
        send_cmd(CMD_LOAD, 3'd2, 16'sd0, 16'd0);
        send_cmd(CMD_LOAD, 3'd3, -16'sd1, 16'd0);
        send_cmd(CMD_LOAD, 3'd4, 16'sd1, 16'd0);
        send_cmd(CMD_LOAD, 3'd5, 16'sh5555, 16'd0);
        send_cmd(CMD_LOAD, 3'd6, -16'sh2AAB, 16'd0);
        send_cmd(CMD_LOAD, 3'd7, 16'sd100, 16'd0);
        send_cmd(CMD_ADD, 3'd0, 16'sd0, 16'd0);
        send_cmd(CMD_ADD, 3'd0, 16'sd32767, 16'hFFFF);
        send_cmd(CMD_ADD, 3'd0, -16'sd32768, 16'hFFFF);
        send_cmd(CMD_ADD, 3'd0, 16'sd1, 16'h0100);
        send_cmd(CMD_ADD, 3'd0, 16'sd1234, 16'h0100);
        send_cmd(CMD_REMOVE, 3'd0, 16'sd1, 16'hFFFF);
        send_cmd(CMD_REMOVE, 3'd0, 16'sd999, 16'h0001);
        send_cmd(CMD_SPARE_5, 3'd7, 16'sd5, 16'd5);
        send_cmd(CMD_SPARE_6, 3'd0, 16'sd0, 16'd0);
        send_cmd(CMD_SPARE_7, 3'd0, 16'sd0, 16'd0);
        send_cmd(CMD_CLEAR, 3'd0, 16'sd0, 16'd0);
        send_cmd(CMD_ADD, 3'd0, 16'sd100, 16'd0);
        send_cmd(CMD_ADD, 3'd0, 16'sh5555, 16'd0);
        send_cmd(CMD_REMOVE, 3'd0, 16'sd100, 16'd0);
        send_cmd(CMD_REMOVE, 3'd0, 16'sd100, 16'd0);
        send_cmd(CMD_REMOVE, 3'd0, 16'sd100, 16'd7);
    endtask

    // Register extremes: missing-value leaf, l2 loss, scale limits, class counts.
    task automatic test_register_extremes();
        set_regs(1'b0, 24'd65536, 1'b1, 4'd8);
        send_cmd(CMD_ADD, 3'd0, 16'sd32767, 16'h1234);
        send_cmd(CMD_QUERY, 3'd0, 16'sd0, 16'd0);
        set_regs(1'b1, 24'hFFFFFF, 1'b0, 4'd15);
        send_cmd(CMD_ADD, 3'd0, -16'sd32768, 16'hFFFF);
        send_cmd(CMD_ADD, 3'd0, 16'sd0, 16'h00FF);
        set_regs(1'b1, 24'd0, 1'b0, 4'd0);
        send_cmd(CMD_ADD, 3'd0, 16'sd32767, 16'h0001);
        send_cmd(CMD_QUERY, 3'd0, 16'sd0, 16'd0);
        set_regs(1'b0, 24'd1, 1'b0, 4'd1);
        send_cmd(CMD_ADD, 3'd0, 16'sd100, 16'h0200);
        send_cmd(CMD_QUERY, 3'd0, 16'sd0, 16'd0);
    endtask

    // One random command, mostly well-formed samples.
    task automatic random_item();
        int pick;
        logic [15:0] w;
        pick = $urandom_range(0, 99);
        w = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                         : 16'($urandom);
        if (pick < 55)
            send_cmd(CMD_ADD, 3'($urandom), known_target(), w);
        else if (pick < 72)
            send_cmd(CMD_REMOVE, 3'($urandom), known_target(), w);
        else if (pick < 80)
            send_cmd(($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_REMOVE,
                     3'($urandom), 16'($urandom), w);
        else if (pick < 86)
            send_cmd(CMD_LOAD, 3'($urandom), ($urandom_range(0, 1) != 0) ?
                     known_target() : 16'($urandom), w);
        else if (pick < 90)
            send_cmd(CMD_CLEAR, 3'($urandom), 16'($urandom), w);
        else
            send_cmd(3'($urandom_range(CMD_QUERY, CMD_SPARE_7)), 3'($urandom),
                     16'($urandom), w);
    endtask

    // Random training runs in chunks, with new register settings per chunk.
    task automatic test_random_training(int items, int sidle, int rstall);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0) begin
                set_regs(1'($urandom), ($urandom_range(0, 7) == 0) ?
                         24'($urandom_range(0, 1) * 24'hFFFFFF) : 24'($urandom),
                         ($urandom_range(0, 5) == 0), 4'($urandom_range(0, 15)));
            end
            random_item();
        end
    endtask

    // Long receiver hold-off while commands keep coming, so the block stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_regs(1'b0, 24'd65536, 1'b0, 4'd8);
        recv_hold = 1'b1;
        fork
            begin
                repeat (1500) @(posedge i_clk);
                recv_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 12; i++) random_item();
    endtask

    initial begin
        fail_count = 0;
        sent_count = 0;
        checked_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        mode_sq = 1'b0;
        scale_q = 24'd65536;
        missing_mode = 1'b0;
        class_limit = 4'd8;
        foreach (class_tab[i]) class_tab[i] = '0;
        foreach (class_sum[i]) class_sum[i] = '0;
        rows = '0;
        weight_total = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_QUERY;
        req_ch.class_index = '0;
        req_ch.target_value = '0;
        req_ch.sample_weight = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_random_training(230, 11, 45);
        test_random_training(230, 45, 11);
        test_backpressure();
        test_random_training(230, 0, 0);
        drain();

        $display("covered %0d command transactions and %0d results: directed corners,",
                 sent_count, checked_count);
        $display("register extremes, random training with idles and a long output stall");
        if (fail_count == 0) begin
            $display("weighted_class_leaf_stats regression: pass");
        end else begin
            $display("weighted_class_leaf_stats regression: fail");
        end
        $finish;
    end

endmodule
